// ===== hw/rtl/periodic_priority_task_scheduler_defines.svh =====
// assertion macros for the task scheduler
// no dependencies
`ifndef PERIODIC_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define PERIODIC_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define PPTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PPTS_ASSERT_NEVER(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define PPTS_ASSERT(label, prop, msg)
`define PPTS_ASSERT_NEVER(label, prop, msg)
`endif
`endif

// ===== hw/rtl/ppts_pkg.sv =====
// types and constants shared by the task scheduler
// no dependencies
package ppts_pkg;
  localparam int unsigned MaxSlotsDef = 8;
  localparam int unsigned IdW = 3;
  localparam logic [15:0] Uint16Max = 16'hffff;

  typedef enum logic [2:0] {
    ST_PERIODIC   = 3'd0,
    ST_BACKGROUND = 3'd1,
    ST_IDLE       = 3'd2,
    ST_ADDED      = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  typedef enum logic {
    REQ_ADD = 1'b0,
    REQ_RUN = 1'b1
  } req_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_tick;
    logic [31:0] task_period;
    logic [31:0] start_delay;
    logic [15:0] task_priority;
  } req_t;

  typedef struct packed {
    logic [2:0]     status;
    logic [IdW-1:0] task_id;
    logic           last;
  } rsp_t;
endpackage

// ===== hw/rtl/periodic_priority_task_scheduler.sv =====
// fixed-priority periodic task scheduler, single module
// depends on ppts_pkg and periodic_priority_task_scheduler_defines.svh
//
// Input channel req (valid/ready) carries add or run requests; output channel
// rsp (valid/ready) carries results, the final one of each request has last set.
// Slot period, release tick and priority live in one synchronous memory
// (one read, one write port, registered read data); used and pending bits
// are flip-flops. An add writes the free slot, then passes on to the output.
// A run reads every slot once to mark due tasks, then per emitted task
// scans all slots for the best pending one and advances its release with a
// 32-step restoring divider; it ends with a background or idle result.
// One request is handled at a time; results leave through a single output
// register, and a stalled receiver holds the sequencer until the transfer.
// Reset clears used and pending bits, the fill count and the round-robin
// pointer; memory contents are only used for used slots.
`include "periodic_priority_task_scheduler_defines.svh"
module periodic_priority_task_scheduler #(
  parameter int unsigned MAX_SLOTS = ppts_pkg::MaxSlotsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  ppts_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output ppts_pkg::rsp_t rsp_o
);
  import ppts_pkg::*;

  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

  typedef struct packed {
    logic [31:0] period;
    logic [31:0] rel;
    logic [15:0] prio;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_MARK, S_SCAN, S_ADV_RD, S_DIV, S_ADV_WR, S_BG, S_OUT
  } state_e;

  state_e         state_q;
  state_e         after_q;
  req_t           req_q;
  entry_t         mem [MAX_SLOTS];
  entry_t         rd_q;
  logic [AW-1:0]  raddr;
  logic           we;
  logic [AW-1:0]  waddr;
  entry_t         wdata;
  logic [MAX_SLOTS-1:0] used_q, pend_q, bg_q;
  logic [CW-1:0]  used_cnt_q;
  logic [AW-1:0]  rr_q;
  logic [CW-1:0]  idx_q;
  logic           rd_vld_q;
  logic [AW-1:0]  rd_idx_q;
  logic           best_vld_q;
  logic [AW-1:0]  best_q;
  logic [15:0]    best_prio_q;
  logic [31:0]    quo_q, rem_q, late_q;
  logic [5:0]     dcnt_q;
  logic [32:0]    rem_sh;
  logic [31:0]    adv;
  logic           rsp_valid_q;
  rsp_t           rsp_q;
  logic [AW-1:0]  first_free;
  logic           bg_found;
  logic [AW-1:0]  bg_idx;
  logic [AW:0]    sum;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_comb begin
    first_free = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) first_free = AW'(i);
    end
  end

  always_comb begin
    bg_found = 1'b0;
    bg_idx = '0;
    for (int o = MAX_SLOTS - 1; o >= 0; o--) begin
      sum = {1'b0, rr_q} + (AW + 1)'(o);
      if (sum >= (AW + 1)'(MAX_SLOTS)) sum = sum - (AW + 1)'(MAX_SLOTS);
      if (used_q[sum[AW-1:0]] && bg_q[sum[AW-1:0]]) begin
        bg_found = 1'b1;
        bg_idx = sum[AW-1:0];
      end
    end
  end

  assign rem_sh = {rem_q, late_q[31]};
  assign adv = rd_q.rel + (quo_q + 32'd1) * rd_q.period;

  always_comb begin
    raddr = idx_q[AW-1:0];
    if (state_q == S_BG || state_q == S_ADV_RD || state_q == S_DIV ||
        state_q == S_ADV_WR) raddr = best_q;
    we = 1'b0;
    waddr = best_q;
    wdata = rd_q;
    if (state_q == S_ADD) begin
      we = 1'b1;
      waddr = first_free;
      wdata.period = req_q.task_period;
      wdata.rel = req_q.now_tick + req_q.start_delay;
      wdata.prio = req_q.task_priority;
    end else if (state_q == S_ADV_WR) begin
      we = 1'b1;
      wdata.rel = adv;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      after_q <= S_IDLE;
      used_q <= '0;
      pend_q <= '0;
      bg_q <= '0;
      used_cnt_q <= '0;
      rr_q <= '0;
      idx_q <= '0;
      rd_vld_q <= 1'b0;
      best_vld_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q <= req_i;
            idx_q <= '0;
            rd_vld_q <= 1'b0;
            best_vld_q <= 1'b0;
            if (req_i.req_type == REQ_ADD) begin
              if (used_cnt_q >= CW'(MAX_SLOTS)) begin
                rsp_q <= '{status: ST_FULL, task_id: '0, last: 1'b1};
                rsp_valid_q <= 1'b1;
                state_q <= S_OUT;
                after_q <= S_IDLE;
              end else begin
                state_q <= S_ADD;
              end
            end else begin
              state_q <= S_MARK;
            end
          end
        end
        S_ADD: begin
          used_q[first_free] <= 1'b1;
          pend_q[first_free] <= 1'b0;
          bg_q[first_free] <= (req_q.task_period == '0);
          used_cnt_q <= used_cnt_q + CW'(1);
          rsp_q <= '{status: ST_ADDED, task_id: IdW'(first_free), last: 1'b1};
          rsp_valid_q <= 1'b1;
          state_q <= S_OUT;
          after_q <= S_IDLE;
        end
        S_MARK: begin
          if (rd_vld_q && used_q[rd_idx_q] && rd_q.period != '0 &&
              !(req_q.now_tick - rd_q.rel >= 32'h8000_0000)) begin
            pend_q[rd_idx_q] <= 1'b1;
          end
          rd_idx_q <= idx_q[AW-1:0];
          if (idx_q == CW'(MAX_SLOTS)) begin
            idx_q <= '0;
            rd_vld_q <= 1'b0;
            best_vld_q <= 1'b0;
            state_q <= S_SCAN;
          end else begin
            rd_vld_q <= 1'b1;
            idx_q <= idx_q + CW'(1);
          end
        end
        S_SCAN: begin
          if (rd_vld_q && used_q[rd_idx_q] && pend_q[rd_idx_q] && !bg_q[rd_idx_q] &&
              (!best_vld_q || rd_q.prio < best_prio_q)) begin
            best_vld_q <= 1'b1;
            best_q <= rd_idx_q;
            best_prio_q <= rd_q.prio;
          end
          rd_idx_q <= idx_q[AW-1:0];
          if (idx_q == CW'(MAX_SLOTS)) begin
            idx_q <= '0;
            rd_vld_q <= 1'b0;
            state_q <= S_BG;
          end else begin
            rd_vld_q <= 1'b1;
            idx_q <= idx_q + CW'(1);
          end
        end
        S_BG: begin
          if (best_vld_q) begin
            state_q <= S_ADV_RD;
          end else begin
            if (bg_found) begin
              rr_q <= (bg_idx == AW'(MAX_SLOTS - 1)) ? '0 : bg_idx + AW'(1);
              rsp_q <= '{status: ST_BACKGROUND, task_id: IdW'(bg_idx), last: 1'b1};
            end else begin
              rsp_q <= '{status: ST_IDLE, task_id: '0, last: 1'b1};
            end
            rsp_valid_q <= 1'b1;
            state_q <= S_OUT;
            after_q <= S_IDLE;
          end
        end
        S_ADV_RD: begin
          state_q <= S_DIV;
          dcnt_q <= '0;
          quo_q <= '0;
          rem_q <= '0;
          late_q <= req_q.now_tick - rd_q.rel;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, rd_q.period}) begin
            rem_q <= 32'(rem_sh - {1'b0, rd_q.period});
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh[31:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
          late_q <= {late_q[30:0], 1'b0};
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd31) state_q <= S_ADV_WR;
        end
        S_ADV_WR: begin
          pend_q[best_q] <= 1'b0;
          rsp_q <= '{status: ST_PERIODIC, task_id: IdW'(best_q), last: 1'b0};
          rsp_valid_q <= 1'b1;
          state_q <= S_OUT;
          after_q <= S_SCAN;
          idx_q <= '0;
          rd_vld_q <= 1'b0;
          best_vld_q <= 1'b0;
        end
        S_OUT: begin
          if (rsp_ready_i) begin
            rsp_valid_q <= 1'b0;
            state_q <= after_q;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PPTS_ASSERT(a_out_hold, (state_q == S_OUT) |-> rsp_valid_q, "result lost")
  `PPTS_ASSERT_NEVER(a_cnt_range, used_cnt_q > CW'(MAX_SLOTS), "fill count overflow")
  `PPTS_ASSERT(a_cnt_match, $countones(used_q) == int'(used_cnt_q), "fill count mismatch")
  `PPTS_ASSERT_NEVER(a_bg_pend, |(pend_q & bg_q & used_q), "background slot pending")
  `PPTS_ASSERT(a_add_once, (state_q == S_ADD) |=> (state_q == S_OUT), "add sequence broken")
endmodule

// ===== tb/ppts_checker.sv =====
// scoreboard for the task scheduler: watches both channels, predicts results
// depends on ppts_pkg
module ppts_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  ppts_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_ready_i,
  input  ppts_pkg::rsp_t rsp_i,
  output int             fail_count_o,
  output int             pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppts_pkg::*;

  localparam int Slots = 8;

  logic        used_q [Slots];
  logic        mark_q [Slots];
  logic [31:0] period_q [Slots];
  logic [31:0] release_q [Slots];
  logic [15:0] prio_q [Slots];
  int          fill_q;
  int          rr_q;
  rsp_t        expected_rsp_q [$];

  assign pending_count_o = expected_rsp_q.size();

  function automatic bit tick_reached(logic [31:0] now, logic [31:0] tgt);
    logic [31:0] d;
    d = now - tgt;
    return !d[31];
  endfunction

  function automatic rsp_t mk(status_e s, int id, bit l);
    rsp_t r;
    r.status = s;
    r.task_id = id[2:0];
    r.last = l;
    return r;
  endfunction

  task automatic predict_schedule(req_t rq);
    int best;
    int idx;
    bit found;
    logic [31:0] late;
    if (rq.req_type == REQ_ADD) begin
      found = 0;
      for (int i = 0; i < Slots; i++) begin
        if (!found && !used_q[i]) begin
          found = 1;
          used_q[i] = 1;
          period_q[i] = rq.task_period;
          release_q[i] = rq.now_tick + rq.start_delay;
          prio_q[i] = rq.task_priority;
          mark_q[i] = 0;
          fill_q++;
          expected_rsp_q.push_back(mk(ST_ADDED, i, 1));
        end
      end
      if (!found) expected_rsp_q.push_back(mk(ST_FULL, 0, 1));
      return;
    end
    for (int i = 0; i < Slots; i++) begin
      if (used_q[i] && period_q[i] != 0 && tick_reached(rq.now_tick, release_q[i])) begin
        mark_q[i] = 1;
      end
    end
    for (int r = 0; r < Slots; r++) begin
      best = -1;
      for (int i = 0; i < Slots; i++) begin
        if (used_q[i] && mark_q[i] && period_q[i] != 0) begin
          if (best < 0 || prio_q[i] < prio_q[best]) best = i;
        end
      end
      if (best < 0) break;
      mark_q[best] = 0;
      if (tick_reached(rq.now_tick, release_q[best])) begin
        late = rq.now_tick - release_q[best];
        release_q[best] = release_q[best] + (late / period_q[best] + 1) * period_q[best];
      end
      expected_rsp_q.push_back(mk(ST_PERIODIC, best, 0));
    end
    found = 0;
    for (int off = 0; off < Slots; off++) begin
      idx = (rr_q + off) % Slots;
      if (!found && used_q[idx] && period_q[idx] == 0) begin
        found = 1;
        rr_q = (idx + 1) % Slots;
        expected_rsp_q.push_back(mk(ST_BACKGROUND, idx, 1));
      end
    end
    if (!found) expected_rsp_q.push_back(mk(ST_IDLE, 0, 1));
  endtask

  task automatic report_mismatch(string what, rsp_t got, rsp_t want);
    $display("mismatch %s: got st=%0d id=%0d last=%0d want st=%0d id=%0d last=%0d",
             what, got.status, got.task_id, got.last,
             want.status, want.task_id, want.last);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    fill_q = 0;
    rr_q = 0;
    for (int i = 0; i < Slots; i++) begin
      used_q[i] = 0;
      mark_q[i] = 0;
      period_q[i] = '0;
      release_q[i] = '0;
      prio_q[i] = '0;
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected transfer", rsp_i, '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.status != want.status) report_mismatch("status", rsp_i, want);
          else if (rsp_i.task_id != want.task_id) report_mismatch("task_id", rsp_i, want);
          else if (rsp_i.last != want.last) report_mismatch("last", rsp_i, want);
        end
      end
      if (req_valid_i && req_ready_i) predict_schedule(req_i);
    end
  end
endmodule

// ===== tb/tb_periodic_priority_task_scheduler.sv =====
// top of the task scheduler testbench: clock, reset, stimulus and verdict
// depends on ppts_pkg, ppts_checker and the scheduler rtl
module tb_periodic_priority_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import ppts_pkg::*;

  localparam longint CycleLimit = 2000000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 0;
  longint cycle_count = 0;
  logic [31:0] now_q = 0;

  always #5 clk_i = ~clk_i;

  periodic_priority_task_scheduler u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp)
  );

  ppts_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid), .req_ready_i(req_ready), .req_i(req),
    .rsp_valid_i(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_i(rsp),
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[periodic_priority_task_scheduler] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // valid is dropped by the next idle cycle or by drain, never twice in one step
  task automatic send_req(req_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk_i);
    end
    req_valid <= 1;
    req <= rq;
    do @(posedge clk_i); while (!req_ready);
  endtask

  function automatic req_t mk_add(logic [31:0] now, logic [31:0] per,
                                  logic [31:0] dly, logic [15:0] pr);
    req_t r;
    r.req_type = REQ_ADD;
    r.now_tick = now;
    r.task_period = per;
    r.start_delay = dly;
    r.task_priority = pr;
    return r;
  endfunction

  function automatic req_t mk_run(logic [31:0] now);
    req_t r;
    r.req_type = REQ_RUN;
    r.now_tick = now;
    r.task_period = $urandom;
    r.start_delay = $urandom;
    r.task_priority = 16'($urandom);
    return r;
  endfunction

  task automatic drain();
    req_valid <= 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  initial begin
    req_t rq;
    int pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: run on empty table, fill, full, wrap and extremes
    send_req(mk_run(32'h0));
    send_req(mk_add(32'hffff_fff0, 32'd1, 32'h20, 16'hffff));
    send_req(mk_add(32'h0, 32'hffff_ffff, 32'h0, 16'h0));
    send_req(mk_add(32'h0, 32'h0, 32'h0, 16'h5));
    send_req(mk_add(32'h10, 32'd7, 32'hffff_ffff, 16'h0));
    send_req(mk_add(32'h10, 32'd3, 32'd2, 16'h8000));
    send_req(mk_add(32'h10, 32'h0, 32'h5, 16'h0));
    send_req(mk_add(32'h10, 32'h8000_0000, 32'h7fff_ffff, 16'h8000));
    send_req(mk_add(32'h10, 32'd100, 32'd1, 16'hffff));
    send_req(mk_add(32'h10, 32'd5, 32'd5, 16'h1));
    send_req(mk_run(32'h0000_0010));
    send_req(mk_run(32'h0000_0020));
    send_req(mk_run(32'h7fff_ffff));
    send_req(mk_run(32'h8000_0010));
    send_req(mk_run(32'hffff_ffff));
    send_req(mk_run(32'h0000_1000));
    drain();
    // random phases over the existing full table, then a pause
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 69; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 69; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (ph == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (600) @(posedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      for (int n = 0; n < 75; n++) begin
        now_q = now_q + $urandom_range(40);
        if ($urandom_range(9) == 0) now_q = $urandom;
        pick = $urandom_range(9);
        if (pick < 2) begin
          rq = mk_add(now_q, ($urandom_range(3) == 0) ? 32'h0 :
                      (($urandom_range(4) == 0) ? $urandom : $urandom_range(1, 30)),
                      ($urandom_range(4) == 0) ? $urandom : $urandom_range(20),
                      16'($urandom));
        end else begin
          rq = mk_run(now_q);
        end
        send_req(rq);
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("[periodic_priority_task_scheduler] OK");
    end else begin
      $display("[periodic_priority_task_scheduler] ERROR");
    end
    $finish;
  end
endmodule
